### design/lrpw_pkg.sv
// ----------------------------------------------------------------------------
// lrpw_pkg: shared types and constants for the line raster pixel writer
// Request payloads, configuration block, register map and command codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lrpw_pkg;

  localparam int unsigned CoordBits  = 12;
  localparam int unsigned ErrBits    = CoordBits + 2;
  localparam int unsigned AddrBits   = 28;
  localparam int unsigned BppBits    = 6;
  localparam int unsigned StrideBits = 16;
  localparam int unsigned ColorBits  = 24;
  localparam int unsigned ApbAddrBits = 4;
  localparam int unsigned ApbDataBits = 32;

  localparam int unsigned XProdBits = CoordBits + BppBits;
  localparam int unsigned YProdBits = CoordBits + StrideBits;
  localparam int unsigned XOffBits  = XProdBits - 3;
  localparam int unsigned SumBits0  = (XOffBits > YProdBits) ? XOffBits : YProdBits;
  localparam int unsigned SumBits   = (SumBits0 > AddrBits) ? SumBits0 : AddrBits;

  localparam logic [BppBits-1:0]    BppReset    = 6'd32;
  localparam logic [StrideBits-1:0] StrideReset = 16'd16384;
  localparam logic                  OrderReset  = 1'b0;
  localparam logic [ColorBits-1:0]  ColorReset  = 24'hFFFFFF;

  typedef enum logic [1:0] {
    RegBpp    = 2'd0,
    RegStride = 2'd1,
    RegOrder  = 2'd2,
    RegColor  = 2'd3
  } reg_idx_e;

  typedef enum logic {
    CmdLoad = 1'b0,
    CmdStep = 1'b1
  } cmd_e;

  typedef enum logic {
    OrderBlueFirst = 1'b0,
    OrderRedFirst  = 1'b1
  } byte_order_e;

  typedef logic [CoordBits-1:0] coord_t;

  typedef struct packed {
    logic   command;
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } in_item_t;

  typedef struct packed {
    coord_t              pixel_x;
    coord_t              pixel_y;
    logic [AddrBits-1:0] byte_address;
    logic [7:0]          first_byte;
    logic [7:0]          second_byte;
    logic [7:0]          third_byte;
    logic                last_pixel;
  } out_item_t;

  typedef struct packed {
    logic [BppBits-1:0]    bits_per_pixel;
    logic [StrideBits-1:0] line_stride;
    logic                  byte_order;
    logic [ColorBits-1:0]  pixel_color;
  } cfg_t;

  // one drawn pixel, straight from the stepper state
  typedef struct packed {
    logic   fire;
    coord_t x;
    coord_t y;
    logic   last;
  } pix_t;

endpackage

`default_nettype wire

### design/lrpw_cfg.sv
// ----------------------------------------------------------------------------
// lrpw_cfg: configuration register file
// APB-style slave holding pixel format, stride, byte order and color.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lrpw_cfg (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [lrpw_pkg::ApbAddrBits-1:0] paddr,
  input  wire logic [lrpw_pkg::ApbDataBits-1:0] pwdata,
  output logic      [lrpw_pkg::ApbDataBits-1:0] prdata,
  output logic                                  pready,
  output lrpw_pkg::cfg_t                        cfg_o
);

  lrpw_pkg::cfg_t     cfg_q, cfg_d;
  lrpw_pkg::reg_idx_e idx;
  logic               wr_en;

  assign idx    = lrpw_pkg::reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        lrpw_pkg::RegBpp:    cfg_d.bits_per_pixel = pwdata[lrpw_pkg::BppBits-1:0];
        lrpw_pkg::RegStride: cfg_d.line_stride    = pwdata[lrpw_pkg::StrideBits-1:0];
        lrpw_pkg::RegOrder:  cfg_d.byte_order     = pwdata[0];
        lrpw_pkg::RegColor:  cfg_d.pixel_color    = pwdata[lrpw_pkg::ColorBits-1:0];
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      lrpw_pkg::RegBpp:    prdata = lrpw_pkg::ApbDataBits'(cfg_q.bits_per_pixel);
      lrpw_pkg::RegStride: prdata = lrpw_pkg::ApbDataBits'(cfg_q.line_stride);
      lrpw_pkg::RegOrder:  prdata = lrpw_pkg::ApbDataBits'(cfg_q.byte_order);
      lrpw_pkg::RegColor:  prdata = lrpw_pkg::ApbDataBits'(cfg_q.pixel_color);
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bits_per_pixel <= lrpw_pkg::BppReset;
      cfg_q.line_stride    <= lrpw_pkg::StrideReset;
      cfg_q.byte_order     <= lrpw_pkg::OrderReset;
      cfg_q.pixel_color    <= lrpw_pkg::ColorReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### design/lrpw_stepper.sv
// ----------------------------------------------------------------------------
// lrpw_stepper: 4-connected Bresenham line state
// Sets up a line on load; on each step emits the cursor and moves one unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lrpw_stepper (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               accept_i,
  input  wire lrpw_pkg::in_item_t item_i,
  output lrpw_pkg::pix_t          pix_o
);

  localparam int unsigned EB = lrpw_pkg::ErrBits;

  lrpw_pkg::coord_t cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  lrpw_pkg::coord_t tgt_x_q, tgt_x_d, tgt_y_q, tgt_y_d;
  lrpw_pkg::coord_t dx_q, dx_d, dy_q, dy_d;
  logic             neg_x_q, neg_x_d, neg_y_q, neg_y_d;
  logic signed [EB-1:0] err_q, err_d;
  logic             active_q, active_d;

  lrpw_pkg::coord_t  ld_dx, ld_dy, nx_x, nx_y;
  logic signed [EB:0] err2, neg_dy;
  logic              move_x, is_load, fire, last;

  assign is_load = accept_i && (item_i.command == lrpw_pkg::CmdLoad);
  assign fire    = accept_i && (item_i.command == lrpw_pkg::CmdStep) && active_q;

  assign ld_dx = (item_i.start_x > item_i.end_x) ? item_i.start_x - item_i.end_x
                                                 : item_i.end_x - item_i.start_x;
  assign ld_dy = (item_i.start_y > item_i.end_y) ? item_i.start_y - item_i.end_y
                                                 : item_i.end_y - item_i.start_y;

  // 2*err > -dy picks the x move
  assign err2   = {err_q, 1'b0};
  assign neg_dy = -$signed({3'b000, dy_q});
  assign move_x = err2 > neg_dy;

  assign nx_x = move_x ? (neg_x_q ? cur_x_q - 1'b1 : cur_x_q + 1'b1) : cur_x_q;
  assign nx_y = move_x ? cur_y_q : (neg_y_q ? cur_y_q - 1'b1 : cur_y_q + 1'b1);
  assign last = (nx_x == tgt_x_q) && (nx_y == tgt_y_q);

  always_comb begin
    cur_x_d  = cur_x_q;
    cur_y_d  = cur_y_q;
    tgt_x_d  = tgt_x_q;
    tgt_y_d  = tgt_y_q;
    dx_d     = dx_q;
    dy_d     = dy_q;
    neg_x_d  = neg_x_q;
    neg_y_d  = neg_y_q;
    err_d    = err_q;
    active_d = active_q;
    if (is_load) begin
      cur_x_d  = item_i.start_x;
      cur_y_d  = item_i.start_y;
      tgt_x_d  = item_i.end_x;
      tgt_y_d  = item_i.end_y;
      dx_d     = ld_dx;
      dy_d     = ld_dy;
      neg_x_d  = !(item_i.start_x < item_i.end_x);
      neg_y_d  = !(item_i.start_y < item_i.end_y);
      err_d    = $signed({2'b00, ld_dx}) - $signed({2'b00, ld_dy});
      active_d = (item_i.start_x != item_i.end_x) || (item_i.start_y != item_i.end_y);
    end else if (fire) begin
      cur_x_d  = nx_x;
      cur_y_d  = nx_y;
      err_d    = move_x ? err_q - $signed({2'b00, dy_q}) : err_q + $signed({2'b00, dx_q});
      active_d = !last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q  <= '0;
      cur_y_q  <= '0;
      tgt_x_q  <= '0;
      tgt_y_q  <= '0;
      dx_q     <= '0;
      dy_q     <= '0;
      neg_x_q  <= 1'b0;
      neg_y_q  <= 1'b0;
      err_q    <= '0;
      active_q <= 1'b0;
    end else begin
      cur_x_q  <= cur_x_d;
      cur_y_q  <= cur_y_d;
      tgt_x_q  <= tgt_x_d;
      tgt_y_q  <= tgt_y_d;
      dx_q     <= dx_d;
      dy_q     <= dy_d;
      neg_x_q  <= neg_x_d;
      neg_y_q  <= neg_y_d;
      err_q    <= err_d;
      active_q <= active_d;
    end
  end

  assign pix_o.fire = fire;
  assign pix_o.x    = cur_x_q;
  assign pix_o.y    = cur_y_q;
  assign pix_o.last = last;

  // a step moves on exactly one axis
  a_one_axis: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> ((cur_x_q != $past(cur_x_q)) != (cur_y_q != $past(cur_y_q))))
    else $error("stepper moved on zero or two axes");

  // a degenerate load leaves nothing to draw
  a_zero_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (is_load && (item_i.start_x == item_i.end_x) && (item_i.start_y == item_i.end_y))
    |=> !active_q)
    else $error("zero-length line left active");

  // the final pixel ends the line
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && last) |=> !active_q)
    else $error("line still active after last pixel");

endmodule

`default_nettype wire

### design/line_raster_pixel_writer.sv
// ----------------------------------------------------------------------------
// line_raster_pixel_writer: 4-connected Bresenham line pixel generator
// Path: an accepted step's pixel is registered in stage 1, then at the output;
//   a load request, or a step with no line active, gives no result.
// Throughput: one request per cycle when in_stall_o is low, set by the
//   error/cursor loop. Products are registered before the address add.
// Reset: line state and pipeline valids clear; registers take their defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module line_raster_pixel_writer (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire lrpw_pkg::in_item_t               in_data_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output lrpw_pkg::out_item_t                   out_data_o,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [lrpw_pkg::ApbAddrBits-1:0] paddr,
  input  wire logic [lrpw_pkg::ApbDataBits-1:0] pwdata,
  output logic      [lrpw_pkg::ApbDataBits-1:0] prdata,
  output logic                                  pready
);

  lrpw_pkg::cfg_t      cfg;
  lrpw_pkg::pix_t      pix;
  lrpw_pkg::out_item_t out_q, out_d;
  logic                out_valid_q;
  logic                s1_valid_q;
  lrpw_pkg::coord_t    s1_x_q, s1_y_q;
  logic                s1_last_q;
  logic [7:0]          s1_b0_q, s1_b1_q, s1_b2_q;
  logic [lrpw_pkg::XProdBits-1:0] s1_xp_q;
  logic [lrpw_pkg::YProdBits-1:0] s1_yp_q;
  logic                adv_out, adv_s1, in_acc;
  logic [lrpw_pkg::SumBits-1:0] addr_sum;

  lrpw_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign adv_out    = !out_valid_q || !out_stall_i;
  assign adv_s1     = !s1_valid_q || adv_out;
  assign in_stall_o = !adv_s1;
  assign in_acc     = in_valid_i && adv_s1;

  lrpw_stepper u_step (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_acc),
    .item_i   (in_data_i),
    .pix_o    (pix)
  );

  // stage 1: cursor and multiplies
  always_ff @(posedge clk_i) begin
    if (adv_s1) begin
      s1_x_q    <= pix.x;
      s1_y_q    <= pix.y;
      s1_last_q <= pix.last;
      s1_xp_q   <= lrpw_pkg::XProdBits'(pix.x) * lrpw_pkg::XProdBits'(cfg.bits_per_pixel);
      s1_yp_q   <= lrpw_pkg::YProdBits'(pix.y) * lrpw_pkg::YProdBits'(cfg.line_stride);
      if (cfg.byte_order == lrpw_pkg::OrderRedFirst) begin
        s1_b0_q <= cfg.pixel_color[23:16];
        s1_b2_q <= cfg.pixel_color[7:0];
      end else begin
        s1_b0_q <= cfg.pixel_color[7:0];
        s1_b2_q <= cfg.pixel_color[23:16];
      end
      s1_b1_q <= cfg.pixel_color[15:8];
    end
  end

  // stage 2: address add, wraps to the address width
  assign addr_sum = lrpw_pkg::SumBits'(s1_xp_q[lrpw_pkg::XProdBits-1:3])
                  + lrpw_pkg::SumBits'(s1_yp_q);

  always_comb begin
    out_d.pixel_x      = s1_x_q;
    out_d.pixel_y      = s1_y_q;
    out_d.byte_address = addr_sum[lrpw_pkg::AddrBits-1:0];
    out_d.first_byte   = s1_b0_q;
    out_d.second_byte  = s1_b1_q;
    out_d.third_byte   = s1_b2_q;
    out_d.last_pixel   = s1_last_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv_out) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv_s1) begin
        s1_valid_q <= pix.fire;
      end
      if (adv_out) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // input only stalls when both stages hold pixels
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q))
    else $error("input stalled with room in the pipeline");

  // a pixel in stage 1 with an empty output moves on
  a_s1_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !out_valid_q) |=> out_valid_q)
    else $error("stage 1 pixel did not reach the output");

  // a drawn pixel lands in stage 1
  a_fire_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix.fire |=> s1_valid_q)
    else $error("step request lost before stage 1");

endmodule

`default_nettype wire

### test/line_raster_pixel_writer_test.sv
// ----------------------------------------------------------------------------
// line_raster_pixel_writer_test: self-checking bench for the line pixel writer
// A short directed table walks the corner cases of line setup and stepping.
// Random line requests then run under several register settings. Both sides
// idle at random, and the sink holds off once for a long stretch. Each pixel
// is checked against a typed row or a behavioral line tracer fed the requests.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module line_raster_pixel_writer_test;

  import lrpw_pkg::*;

  localparam int ClkPeriod    = 10;
  localparam int ResetCycles  = 12;
  localparam int CycleLimit   = 400000;
  localparam int HoldCycles   = 400;
  localparam int SettleCycles = 4;
  localparam int Phases       = 6;
  localparam int RandomItems  = 2000;
  localparam int IdlePct      = 25;
  localparam int CoordMax     = (1 << CoordBits) - 1;

  typedef struct {
    in_item_t  req;
    bit        typed;
    out_item_t want;
  } directed_row_t;

  logic                   clk_i      = 1'b0;
  logic                   rst_ni     = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   in_stall_o;
  in_item_t               in_data_i  = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  out_item_t              out_data_o;
  logic                   psel    = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite  = 1'b0;
  logic [ApbAddrBits-1:0] paddr   = '0;
  logic [ApbDataBits-1:0] pwdata  = '0;
  logic [ApbDataBits-1:0] prdata;
  logic                   pready;

  // tracer state, a copy of what the block should hold
  cfg_t   cur_cfg = '{BppReset, StrideReset, OrderReset, ColorReset};
  coord_t line_x  = '0;
  coord_t line_y  = '0;
  coord_t goal_x  = '0;
  coord_t goal_y  = '0;
  int     span_x  = 0;
  int     span_y  = 0;
  bit     x_down  = 1'b0;
  bit     y_down  = 1'b0;
  int     bres_err = 0;
  bit     drawing = 1'b0;

  out_item_t     pixels_due[$];
  directed_row_t plan[$];

  int  mismatches   = 0;
  int  work_items   = 0;
  int  cycles       = 0;
  bit  quiet        = 1'b0;
  int  holds_asked  = 0;
  int  holds_served = 0;
  int  hold_left    = 0;

  line_raster_pixel_writer u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // One request through the line tracer. A load sets up the line, a step
  // draws the cursor pixel and moves one unit on a single axis.
  function automatic void trace_request(input in_item_t req, output bit drawn,
                                        output out_item_t pix);
    longint offset;
    drawn = 1'b0;
    pix   = '0;
    if (req.command == CmdLoad) begin
      line_x   = req.start_x;
      line_y   = req.start_y;
      goal_x   = req.end_x;
      goal_y   = req.end_y;
      span_x   = (req.start_x > req.end_x) ? int'(req.start_x - req.end_x)
                                           : int'(req.end_x - req.start_x);
      span_y   = (req.start_y > req.end_y) ? int'(req.start_y - req.end_y)
                                           : int'(req.end_y - req.start_y);
      x_down   = !(req.start_x < req.end_x);
      y_down   = !(req.start_y < req.end_y);
      bres_err = span_x - span_y;
      drawing  = (req.start_x != req.end_x) || (req.start_y != req.end_y);
    end else if (drawing) begin
      drawn  = 1'b1;
      offset = longint'(line_x) * longint'(cur_cfg.bits_per_pixel) / 8
             + longint'(line_y) * longint'(cur_cfg.line_stride);
      pix.pixel_x      = line_x;
      pix.pixel_y      = line_y;
      pix.byte_address = offset[AddrBits-1:0];
      pix.second_byte  = cur_cfg.pixel_color[15:8];
      if (cur_cfg.byte_order == OrderBlueFirst) begin
        pix.first_byte = cur_cfg.pixel_color[7:0];
        pix.third_byte = cur_cfg.pixel_color[23:16];
      end else begin
        pix.first_byte = cur_cfg.pixel_color[23:16];
        pix.third_byte = cur_cfg.pixel_color[7:0];
      end
      if (2 * bres_err > -span_y) begin
        bres_err -= span_y;
        line_x = x_down ? line_x - 1'b1 : line_x + 1'b1;
      end else begin
        bres_err += span_x;
        line_y = y_down ? line_y - 1'b1 : line_y + 1'b1;
      end
      pix.last_pixel = (line_x == goal_x) && (line_y == goal_y);
      if (pix.last_pixel) drawing = 1'b0;
    end
  endfunction

  function automatic in_item_t make_req(cmd_e cmd, int sx, int sy, int ex, int ey);
    in_item_t req;
    req.command = cmd;
    req.start_x = coord_t'(sx);
    req.start_y = coord_t'(sy);
    req.end_x   = coord_t'(ex);
    req.end_y   = coord_t'(ey);
    return req;
  endfunction

  function automatic out_item_t pixel_rec(int x, int y, int addr, int b0, int b1, int b2,
                                          bit last);
    out_item_t pix;
    pix.pixel_x      = coord_t'(x);
    pix.pixel_y      = coord_t'(y);
    pix.byte_address = AddrBits'(addr);
    pix.first_byte   = 8'(b0);
    pix.second_byte  = 8'(b1);
    pix.third_byte   = 8'(b2);
    pix.last_pixel   = last;
    return pix;
  endfunction

  function automatic void add_row(in_item_t req, bit typed = 1'b0, out_item_t want = '0);
    directed_row_t row;
    row.req   = req;
    row.typed = typed;
    row.want  = want;
    plan.push_back(row);
  endfunction

  function automatic in_item_t random_step();
    return make_req(CmdStep, $urandom_range(0, CoordMax), $urandom_range(0, CoordMax),
                    $urandom_range(0, CoordMax), $urandom_range(0, CoordMax));
  endfunction

  function automatic coord_t near_coord(coord_t c);
    int v;
    v = int'(c) + int'($urandom_range(0, 24)) - 12;
    if (v < 0) v = 0;
    if (v > CoordMax) v = CoordMax;
    return coord_t'(v);
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
    end
  endfunction

  // drive one request; a typed row overrides the traced pixel
  task automatic send_request(input in_item_t req, input bit typed = 1'b0,
                              input out_item_t want = '0);
    bit        drawn;
    out_item_t pix;
    while (!quiet && $urandom_range(0, 99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (in_stall_o);
    trace_request(req, drawn, pix);
    if (drawn) pixels_due.push_back(typed ? want : pix);
    if (drawn || req.command == CmdLoad) work_items++;
    @(negedge clk_i);
  endtask

  // quiesce: no request offered, all pixels in, pipeline flushed
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pixels_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [31:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      RegBpp:    cur_cfg.bits_per_pixel = value[BppBits-1:0];
      RegStride: cur_cfg.line_stride    = value[StrideBits-1:0];
      RegOrder:  cur_cfg.byte_order     = value[0];
      RegColor:  cur_cfg.pixel_color    = value[ColorBits-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // mostly a load followed by its full run of steps; some lines are cut short,
  // some overrun into ignored steps, some are long and only partly drawn
  task automatic random_line();
    in_item_t req;
    int       style;
    int       len;
    int       n;
    style = $urandom_range(0, 99);
    if (style < 6) begin
      req = random_step();
      req.command = cmd_e'($urandom_range(0, 1));
      send_request(req);
      return;
    end
    req = make_req(CmdLoad, $urandom_range(0, CoordMax), $urandom_range(0, CoordMax), 0, 0);
    if (style < 16) begin
      req.end_x = coord_t'($urandom_range(0, CoordMax));
      req.end_y = coord_t'($urandom_range(0, CoordMax));
    end else begin
      req.end_x = near_coord(req.start_x);
      req.end_y = near_coord(req.start_y);
    end
    send_request(req);
    len = ((req.start_x > req.end_x) ? int'(req.start_x - req.end_x)
                                     : int'(req.end_x - req.start_x))
        + ((req.start_y > req.end_y) ? int'(req.start_y - req.end_y)
                                     : int'(req.end_y - req.start_y));
    if (style < 16)      n = $urandom_range(0, 40);
    else if (style < 26) n = $urandom_range(0, len);
    else if (style < 32) n = len + $urandom_range(1, 3);
    else                 n = len;
    repeat (n) send_request(random_step());
  endtask

  // sink: random stall, a quiet stretch, and one long hold-off on request
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left = hold_left - 1;
    end else if (holds_served != holds_asked) begin
      holds_served = holds_asked;
      hold_left    = HoldCycles;
      out_stall_i <= 1'b1;
    end else if (quiet) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < IdlePct);
    end
  end

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pixels_due.size() == 0) begin
        mismatches++;
        $error("unexpected pixel x=%0d y=%0d", out_data_o.pixel_x, out_data_o.pixel_y);
      end else begin
        want = pixels_due.pop_front();
        check_field("pixel_x",      want.pixel_x,      out_data_o.pixel_x);
        check_field("pixel_y",      want.pixel_y,      out_data_o.pixel_y);
        check_field("byte_address", want.byte_address, out_data_o.byte_address);
        check_field("first_byte",   want.first_byte,   out_data_o.first_byte);
        check_field("second_byte",  want.second_byte,  out_data_o.second_byte);
        check_field("third_byte",   want.third_byte,   out_data_o.third_byte);
        check_field("last_pixel",   want.last_pixel,   out_data_o.last_pixel);
      end
    end
  end

  initial begin
    cfg_t cfg;
    int   goal;

    // reset registers: 32 bpp, stride 16384, blue first, white
    add_row(make_req(CmdStep, CoordMax, CoordMax, CoordMax, CoordMax));  // no line yet
    add_row(make_req(CmdLoad, 0, 0, 0, 0));                              // zero length
    add_row(make_req(CmdStep, 0, 0, 0, 0));
    add_row(make_req(CmdLoad, 0, 0, 1, 0));
    add_row(make_req(CmdStep, CoordMax, 0, CoordMax, 0), 1'b1,
            pixel_rec(0, 0, 0, 8'hFF, 8'hFF, 8'hFF, 1'b1));
    add_row(make_req(CmdStep, 0, 0, 0, 0));                              // line finished
    add_row(make_req(CmdLoad, CoordMax, CoordMax, CoordMax - 1, CoordMax));
    add_row(make_req(CmdStep, 12'hA5A, 12'h5A5, 12'hA5A, 12'h5A5), 1'b1,
            pixel_rec(CoordMax, CoordMax, 28'h3FFFFFC, 8'hFF, 8'hFF, 8'hFF, 1'b1));
    add_row(make_req(CmdLoad, 0, 0, 0, CoordMax));
    add_row(make_req(CmdStep, 0, 0, 0, 0), 1'b1,
            pixel_rec(0, 0, 0, 8'hFF, 8'hFF, 8'hFF, 1'b0));
    add_row(make_req(CmdStep, 0, 0, 0, 0), 1'b1,
            pixel_rec(0, 1, 16384, 8'hFF, 8'hFF, 8'hFF, 1'b0));
    add_row(make_req(CmdLoad, CoordMax, 0, 0, CoordMax));                // replaces live line
    repeat (4) add_row(random_step());
    add_row(make_req(CmdLoad, 10, 3, 13, 3));                            // flat in y
    repeat (3) add_row(random_step());
    add_row(make_req(CmdLoad, 7, 9, 7, 6));                              // flat in x, going up
    repeat (3) add_row(random_step());

    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (plan[i]) send_request(plan[i].req, plan[i].typed, plan[i].want);

    for (int phase = 0; phase < Phases; phase++) begin
      settle();
      case (phase)
        0: cfg = '{6'd8, 16'd0, OrderBlueFirst, 24'h000000};
        1: cfg = '{6'd32, 16'hFFFF, OrderRedFirst, 24'hFFFFFF};
        default: begin
          cfg.bits_per_pixel = BppBits'($urandom_range(8, 32));
          cfg.line_stride    = StrideBits'($urandom_range(0, 16'hFFFF));
          cfg.byte_order     = byte_order_e'($urandom_range(0, 1));
          cfg.pixel_color    = ColorBits'($urandom_range(0, 24'hFFFFFF));
        end
      endcase
      write_reg(RegBpp,    32'(cfg.bits_per_pixel));
      write_reg(RegStride, 32'(cfg.line_stride));
      write_reg(RegOrder,  32'(cfg.byte_order));
      write_reg(RegColor,  32'(cfg.pixel_color));
      quiet = (phase == 3);
      if (phase == 2) holds_asked++;
      goal = work_items + RandomItems / Phases;
      while (work_items < goal) random_line();
    end
    settle();

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### sim.f
design/lrpw_pkg.sv
design/lrpw_cfg.sv
design/lrpw_stepper.sv
design/line_raster_pixel_writer.sv
test/line_raster_pixel_writer_test.sv
